@@ design/hypercube_complement_automorphism_search_top_defines.svh @@
// Assertion macros shared by the complement automorphism search design.
// Included by the modules that carry concurrent assertions; needs no other file.
`ifndef HYPERCUBE_COMPLEMENT_AUTOMORPHISM_SEARCH_TOP_DEFINES_SVH
`define HYPERCUBE_COMPLEMENT_AUTOMORPHISM_SEARCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HCAS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcas assertion failed");
`define HCAS_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("hcas assertion failed");
`else
`define HCAS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define HCAS_ASSERT_DELAY(label, clk, rst, ante, n, cons)
`endif
`endif

@@ design/hcas_pkg.sv @@
// Package for the complement automorphism search: constants, types and the
// elaboration-time permutation table. Depends on nothing.
`timescale 1ns / 1ps

package hcas_pkg;

   localparam int MaxDim         = 5;
   localparam int DefaultCubeDim = 5;
   localparam int MaxVerts       = 32;
   localparam int MaxPerms       = 128;
   localparam int MaxIdxW        = 7;
   localparam int FlipW          = 5;
   localparam int PermFieldW     = 3;
   localparam int GroupSize      = 8;
   localparam int GroupIdxW      = 3;

   typedef logic [MaxDim-1:0][PermFieldW-1:0] perm_type;
   typedef perm_type [MaxPerms-1:0] perm_tab_type;

   typedef struct packed {
      logic               valid;
      logic               found;
      logic [MaxIdxW-1:0] idx;
      logic [FlipW-1:0]   flip;
   } win_type;

   function automatic int factorial(input int n);
      int r;
      r = 1;
      for (int k = 2; k <= n; k++) begin
         r = r * k;
      end
      return r;
   endfunction

   function automatic perm_type next_perm(input perm_type p, input int dim);
      perm_type q;
      perm_type r;
      int i;
      int j;
      i = -1;
      j = 0;
      q = p;
      r = p;
      for (int m = 0; m < MaxDim - 1; m++) begin
         if (m <= dim - 2 && p[m] < p[m+1]) begin
            i = m;
         end
      end
      if (i >= 0) begin
         for (int m = 0; m < MaxDim; m++) begin
            if (m > i && m < dim && p[m] > p[i]) begin
               j = m;
            end
         end
         q[i] = p[j];
         q[j] = p[i];
         r = q;
         for (int m = 0; m < MaxDim; m++) begin
            if (m > i && m < dim) begin
               r[m] = q[dim + i - m];
            end
         end
      end
      return r;
   endfunction

   // Entry k holds the k-th permutation of the first dim coordinates in
   // lexicographic order; coordinates at or above dim stay in place.
   function automatic perm_tab_type perm_table(input int dim);
      perm_tab_type tab;
      perm_type p;
      for (int b = 0; b < MaxDim; b++) begin
         p[b] = PermFieldW'(b);
      end
      for (int k = 0; k < MaxPerms; k++) begin
         tab[k] = p;
         p = next_perm(p, dim);
      end
      return tab;
   endfunction

   function automatic int map_vertex(input int w, input perm_type p, input int dim);
      int r;
      r = 0;
      for (int b = 0; b < MaxDim; b++) begin
         if (b < dim) begin
            r = r | (((w >> p[b]) & 1) << b);
         end
      end
      return r;
   endfunction

endpackage

@@ design/hcas_match.sv @@
// Match stage: tests every permutation and translation against the complement
// and registers, per permutation, a hit flag and the first matching flip. Uses hcas_pkg.
`timescale 1ns / 1ps

module hcas_match #(
   parameter int CUBE_DIM = hcas_pkg::DefaultCubeDim
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic [(1 << CUBE_DIM)-1:0]               set_bits,
   output logic                                     out_valid,
   output logic [hcas_pkg::factorial(CUBE_DIM)-1:0] hit,
   output logic [hcas_pkg::factorial(CUBE_DIM)-1:0][CUBE_DIM-1:0] flip
);

   localparam int Verts    = 1 << CUBE_DIM;
   localparam int NumFlips = Verts;
   localparam int NumPerms = hcas_pkg::factorial(CUBE_DIM);
   localparam hcas_pkg::perm_tab_type PERM_TAB = hcas_pkg::perm_table(CUBE_DIM);

   logic [NumPerms-1:0][Verts-1:0]    permuted;
   logic [NumFlips-1:0][Verts-1:0]    shifted;
   logic [NumPerms-1:0][NumFlips-1:0] match;

   logic                              valid_ff;
   logic [NumPerms-1:0]               hit_in;
   logic [NumPerms-1:0]               hit_ff;
   logic [NumPerms-1:0][CUBE_DIM-1:0] flip_in;
   logic [NumPerms-1:0][CUBE_DIM-1:0] flip_ff;

   for (genvar p = 0; p < NumPerms; p++) begin : g_perm
      for (genvar w = 0; w < Verts; w++) begin : g_vert
         localparam int Src = hcas_pkg::map_vertex(w, PERM_TAB[p], CUBE_DIM);
         assign permuted[p][w] = set_bits[Src];
      end
   end

   for (genvar f = 0; f < NumFlips; f++) begin : g_flip
      for (genvar w = 0; w < Verts; w++) begin : g_vert
         assign shifted[f][w] = set_bits[w ^ f];
      end
   end

   // A candidate maps the set onto its complement exactly when the
   // translated set and the permuted set disagree at every vertex.
   always_comb begin
      for (int p = 0; p < NumPerms; p++) begin
         for (int f = 0; f < NumFlips; f++) begin
            match[p][f] = &(shifted[f] ^ permuted[p]);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < NumPerms; p++) begin
         hit_in[p]  = |match[p];
         flip_in[p] = '0;
         for (int f = NumFlips - 1; f >= 0; f--) begin
            if (match[p][f]) begin
               flip_in[p] = CUBE_DIM'(f);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      flip_ff <= flip_in;
   end

   assign out_valid = valid_ff;
   assign hit       = hit_ff;
   assign flip      = flip_ff;

endmodule

@@ design/hcas_select.sv @@
// Selection stages: a registered two-level priority tree that finds the first
// matching permutation and its flip. Uses hcas_pkg.
`timescale 1ns / 1ps

module hcas_select #(
   parameter int CUBE_DIM = hcas_pkg::DefaultCubeDim
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic [hcas_pkg::factorial(CUBE_DIM)-1:0] hit,
   input  logic [hcas_pkg::factorial(CUBE_DIM)-1:0][CUBE_DIM-1:0] flip,
   output hcas_pkg::win_type                        win
);

   localparam int NumPerms  = hcas_pkg::factorial(CUBE_DIM);
   localparam int GroupSize = hcas_pkg::GroupSize;
   localparam int NumGroups = (NumPerms + GroupSize - 1) / GroupSize;
   localparam int PadPerms  = NumGroups * GroupSize;
   localparam int GrpW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;
   localparam int LocW      = hcas_pkg::GroupIdxW;

   logic [PadPerms-1:0]                hit_pad;
   logic [PadPerms-1:0][CUBE_DIM-1:0]  flip_pad;

   logic                               s2_valid_ff;
   logic [NumGroups-1:0]               ghit_in;
   logic [NumGroups-1:0]               ghit_ff;
   logic [NumGroups-1:0][LocW-1:0]     gsel_in;
   logic [NumGroups-1:0][LocW-1:0]     gsel_ff;
   logic [NumGroups-1:0][CUBE_DIM-1:0] gflip_in;
   logic [NumGroups-1:0][CUBE_DIM-1:0] gflip_ff;

   logic                               s3_valid_ff;
   logic                               found_in;
   logic                               found_ff;
   logic [hcas_pkg::MaxIdxW-1:0]       idx_in;
   logic [hcas_pkg::MaxIdxW-1:0]       idx_ff;
   logic [hcas_pkg::FlipW-1:0]         wflip_in;
   logic [hcas_pkg::FlipW-1:0]         wflip_ff;

   always_comb begin
      hit_pad  = '0;
      flip_pad = '0;
      for (int p = 0; p < NumPerms; p++) begin
         hit_pad[p]  = hit[p];
         flip_pad[p] = flip[p];
      end
   end

   always_comb begin
      for (int g = 0; g < NumGroups; g++) begin
         ghit_in[g]  = |hit_pad[g*GroupSize +: GroupSize];
         gsel_in[g]  = '0;
         gflip_in[g] = '0;
         for (int l = GroupSize - 1; l >= 0; l--) begin
            if (hit_pad[g*GroupSize + l]) begin
               gsel_in[g]  = LocW'(l);
               gflip_in[g] = flip_pad[g*GroupSize + l];
            end
         end
      end
   end

   always_comb begin
      found_in = |ghit_ff;
      idx_in   = '0;
      wflip_in = '0;
      for (int g = NumGroups - 1; g >= 0; g--) begin
         if (ghit_ff[g]) begin
            idx_in   = hcas_pkg::MaxIdxW'({GrpW'(g), gsel_ff[g]});
            wflip_in = hcas_pkg::FlipW'(gflip_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      ghit_ff  <= ghit_in;
      gsel_ff  <= gsel_in;
      gflip_ff <= gflip_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      wflip_ff <= wflip_in;
   end

   assign win = '{valid: s3_valid_ff, found: found_ff, idx: idx_ff, flip: wflip_ff};

endmodule

@@ design/hypercube_complement_automorphism_search_top.sv @@
// The result strobe follows the accepting edge through the input, match, two select and output registers.
// Throughput: one transaction per cycle; busy is low except around reset.
// The match stage compares all candidate maps at once; a two-level priority tree
// and a permutation table lookup follow. Reset clears every valid bit and holds
// busy high as a registered copy of reset; the receiver cannot stall.
`timescale 1ns / 1ps
`include "hypercube_complement_automorphism_search_top_defines.svh"

module hypercube_complement_automorphism_search_top #(
   parameter int CUBE_DIM = hcas_pkg::DefaultCubeDim
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [hcas_pkg::MaxVerts-1:0]       req_vertex_set,
   output logic                                rsp_valid,
   output logic                                rsp_swaps_halves,
   output logic                                rsp_translation_only,
   output logic [hcas_pkg::FlipW-1:0]          rsp_witness_flip,
   output logic [hcas_pkg::PermFieldW-1:0]     rsp_perm_for_bit_0,
   output logic [hcas_pkg::PermFieldW-1:0]     rsp_perm_for_bit_1,
   output logic [hcas_pkg::PermFieldW-1:0]     rsp_perm_for_bit_2,
   output logic [hcas_pkg::PermFieldW-1:0]     rsp_perm_for_bit_3,
   output logic [hcas_pkg::PermFieldW-1:0]     rsp_perm_for_bit_4
);

   localparam int Verts    = 1 << CUBE_DIM;
   localparam int NumPerms = hcas_pkg::factorial(CUBE_DIM);
   localparam hcas_pkg::perm_tab_type PERM_TAB = hcas_pkg::perm_table(CUBE_DIM);

   logic                              busy_ff;
   logic                              s0_valid_ff;
   logic [Verts-1:0]                  set_ff;
   logic                              s1_valid;
   logic [NumPerms-1:0]               s1_hit;
   logic [NumPerms-1:0][CUBE_DIM-1:0] s1_flip;
   hcas_pkg::win_type                 win;

   logic                              out_valid_ff;
   logic                              swaps_in;
   logic                              swaps_ff;
   logic                              trans_in;
   logic                              trans_ff;
   logic [hcas_pkg::FlipW-1:0]        flip_in;
   logic [hcas_pkg::FlipW-1:0]        flip_ff;
   hcas_pkg::perm_type                perm_in;
   hcas_pkg::perm_type                perm_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= start && !busy_ff;
         out_valid_ff <= win.valid;
      end
   end

   always_ff @(posedge clock) begin
      set_ff <= req_vertex_set[Verts-1:0];
   end

   hcas_match #(
      .CUBE_DIM (CUBE_DIM)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .set_bits  (set_ff),
      .out_valid (s1_valid),
      .hit       (s1_hit),
      .flip      (s1_flip)
   );

   hcas_select #(
      .CUBE_DIM (CUBE_DIM)
   ) u_select (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid),
      .hit      (s1_hit),
      .flip     (s1_flip),
      .win      (win)
   );

   // Table entry zero is the identity, which also serves when nothing matches.
   always_comb begin
      swaps_in = win.found;
      trans_in = win.found && (win.idx == '0);
      flip_in  = win.found ? win.flip : '0;
      perm_in  = PERM_TAB[win.found ? win.idx : '0];
   end

   always_ff @(posedge clock) begin
      swaps_ff <= swaps_in;
      trans_ff <= trans_in;
      flip_ff  <= flip_in;
      perm_ff  <= perm_in;
   end

   assign busy                 = busy_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_swaps_halves     = swaps_ff;
   assign rsp_translation_only = trans_ff;
   assign rsp_witness_flip     = flip_ff;
   assign rsp_perm_for_bit_0   = perm_ff[0];
   assign rsp_perm_for_bit_1   = perm_ff[1];
   assign rsp_perm_for_bit_2   = perm_ff[2];
   assign rsp_perm_for_bit_3   = perm_ff[3];
   assign rsp_perm_for_bit_4   = perm_ff[4];

   `HCAS_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 5, rsp_valid)
   `HCAS_ASSERT_IMPLIES(a_trans_identity, clock, reset, rsp_valid && rsp_translation_only, rsp_swaps_halves && rsp_perm_for_bit_0 == 3'd0 && rsp_perm_for_bit_1 == 3'd1 && rsp_perm_for_bit_2 == 3'd2 && rsp_perm_for_bit_3 == 3'd3 && rsp_perm_for_bit_4 == 3'd4)
   `HCAS_ASSERT_IMPLIES(a_no_witness, clock, reset, rsp_valid && !rsp_swaps_halves, rsp_witness_flip == 5'd0 && !rsp_translation_only && rsp_perm_for_bit_0 == 3'd0 && rsp_perm_for_bit_4 == 3'd4)

endmodule
